// ===== hdl/mac_pkg.sv =====
// shared types and constants for the moving average cross detector
// no dependencies
`default_nettype none
package mac_pkg;
    localparam int SUM_BITS = 42;
    localparam int WIN_BITS = 11;
    localparam int CNT_BITS = 32;
    localparam int DATA_BITS = 32;

    typedef struct packed {
        logic accept;
        logic load;
        logic compare;
        logic div_start;
    } mac_cmd_t;

    typedef struct packed {
        logic div_done;
    } mac_sts_t;
endpackage
`default_nettype wire

// ===== hdl/mac_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on mac_pkg
`default_nettype none
module mac_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [mac_pkg::SUM_BITS-1:0]     dividend,
    input  wire logic [mac_pkg::WIN_BITS-1:0]     divisor,
    output logic                                  done,
    output logic [mac_pkg::SUM_BITS-1:0]          quotient
);
    localparam int CW = $clog2(mac_pkg::SUM_BITS + 1);

    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [mac_pkg::SUM_BITS-1:0]     q_reg, q_next;
    logic [mac_pkg::WIN_BITS-1:0]     rem_reg, rem_next;
    logic [mac_pkg::WIN_BITS:0]       trial;

    always_comb begin
        trial    = {rem_reg, q_reg[mac_pkg::SUM_BITS-1]};
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        if (start) begin
            cnt_next = CW'(mac_pkg::SUM_BITS);
            q_next   = dividend;
            rem_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, divisor}) begin
                rem_next = mac_pkg::WIN_BITS'(trial - {1'b0, divisor});
                q_next   = {q_reg[mac_pkg::SUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[mac_pkg::WIN_BITS-1:0];
                q_next   = {q_reg[mac_pkg::SUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done     = (cnt_reg == '0);
    assign quotient = q_reg;
endmodule
`default_nettype wire

// ===== hdl/mac_ctrl.sv =====
// sequencer for accept, store update, compare, divide and result transfer
// depends on mac_pkg
`default_nettype none
module mac_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output mac_pkg::mac_cmd_t  cmd,
    input  wire mac_pkg::mac_sts_t sts
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_CMP, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (s_tvalid) state_reg <= ST_LOAD;
                ST_LOAD: state_reg <= ST_CMP;
                ST_CMP:  state_reg <= ST_DIV;
                ST_DIV:  if (sts.div_done) state_reg <= ST_OUT;
                ST_OUT:  if (m_tready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready      = (state_reg == ST_IDLE);
    assign m_tvalid      = (state_reg == ST_OUT);
    assign cmd.accept    = s_tready && s_tvalid;
    assign cmd.load      = (state_reg == ST_LOAD);
    assign cmd.compare   = (state_reg == ST_CMP);
    assign cmd.div_start = (state_reg == ST_CMP);
endmodule
`default_nettype wire

// ===== hdl/mac_dp.sv =====
// datapath: delay store, running sum, compare, counters and divider
// depends on mac_pkg and mac_div
`default_nettype none
module mac_dp #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire mac_pkg::mac_cmd_t                 cmd,
    output mac_pkg::mac_sts_t                      sts,
    input  wire logic [mac_pkg::WIN_BITS-1:0]      win,
    input  wire logic [mac_pkg::DATA_BITS-1:0]     sample_in,
    input  wire logic                              restart_in,
    output logic [mac_pkg::DATA_BITS-1:0]          average_value,
    output logic                                   average_valid,
    output logic                                   cross_up,
    output logic [mac_pkg::CNT_BITS-1:0]           sample_index,
    output logic [mac_pkg::CNT_BITS-1:0]           cross_count
);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = (SAMPLE_BITS < mac_pkg::DATA_BITS) ? SAMPLE_BITS : mac_pkg::DATA_BITS;
    localparam int SB = mac_pkg::SUM_BITS;
    localparam int PB = mac_pkg::DATA_BITS + mac_pkg::WIN_BITS;

    logic [SW-1:0]    store_mem [MAX_WINDOW];
    logic [SW-1:0]    rd_reg;

    logic [SB-1:0]                     sum_reg;
    logic [mac_pkg::CNT_BITS-1:0]      pos_reg, idx_reg, crosses_reg;
    logic                              prev_below_reg, valid_reg, cross_reg;
    logic [AW-1:0]                     wp_reg;
    logic [SW-1:0]                     sample_reg;
    logic [PB-1:0]                     scaled_reg;

    logic [AW-1:0]    wp_eff, rd_addr;
    logic [31:0]      wp32, w32;
    logic [SB-1:0]    sum_add, sum_new;
    logic             full_win, above, below;
    logic             div_done;
    logic [SB-1:0]    quotient;

    assign wp_eff = restart_in ? '0 : wp_reg;
    assign wp32   = 32'(wp_eff);
    assign w32    = 32'(win);

    // slot that falls out of the window, read before this sample is written
    always_comb begin
        if (wp32 >= w32) begin
            rd_addr = AW'(wp32 - w32);
        end else begin
            rd_addr = AW'(wp32 + 32'(MAX_WINDOW) - w32);
        end
    end

    assign full_win = ({1'b0, idx_reg} >= 33'(win));
    assign sum_add  = sum_reg + SB'(sample_reg);
    assign sum_new  = full_win ? (sum_add - SB'(rd_reg)) : sum_add;
    assign above    = valid_reg && ({1'b0, scaled_reg} > 44'(sum_reg));
    assign below    = valid_reg && ({1'b0, scaled_reg} < 44'(sum_reg));

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_reg <= store_mem[rd_addr];
        end
        if (cmd.load) begin
            store_mem[wp_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg        <= '0;
            pos_reg        <= '0;
            prev_below_reg <= 1'b0;
            crosses_reg    <= '0;
            wp_reg         <= '0;
            valid_reg      <= 1'b0;
            cross_reg      <= 1'b0;
        end else begin
            if (cmd.accept) begin
                sample_reg <= sample_in[SW-1:0];
                idx_reg    <= restart_in ? '0 : pos_reg;
                wp_reg     <= wp_eff;
                if (restart_in) begin
                    sum_reg        <= '0;
                    prev_below_reg <= 1'b0;
                    crosses_reg    <= '0;
                end
            end
            if (cmd.load) begin
                sum_reg    <= sum_new;
                wp_reg     <= (32'(wp_reg) == 32'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                scaled_reg <= PB'(sample_reg) * PB'(win);
                valid_reg  <= ({1'b0, idx_reg} + 33'd1) >= 33'(win);
                pos_reg    <= (idx_reg == '1) ? idx_reg : idx_reg + 1'b1;
            end
            if (cmd.compare) begin
                prev_below_reg <= below;
                cross_reg      <= full_win && prev_below_reg && above;
                if (full_win && prev_below_reg && above && crosses_reg != '1) begin
                    crosses_reg <= crosses_reg + 1'b1;
                end
            end
        end
    end

    mac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (win),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sts.div_done  = div_done;
    assign average_value = valid_reg ? quotient[mac_pkg::DATA_BITS-1:0] : '0;
    assign average_valid = valid_reg;
    assign cross_up      = cross_reg;
    assign sample_index  = idx_reg;
    assign cross_count   = crosses_reg;
endmodule
`default_nettype wire

// ===== hdl/moving_average_cross_detector.sv =====
// moving average cross detector: one sample in, one result out
// each input transfer passes through store read and sum update, compare and the
// bit-serial divide before the result is valid; a new sample is accepted only after
// the result transfer completes, so a stall on m_tready holds off the next sample
// reset: aresetn synchronous active low clears sum, index, counts, pointer, window=1
// depends on mac_pkg, mac_ctrl, mac_dp
`default_nettype none
module moving_average_cross_detector #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // window length register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mac_pkg::WIN_BITS-1:0]  cfg_data,
    // sample stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,  // sample_value
    input  wire logic [0:0]                    s_tuser,  // new_series
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [95:0]                        m_tdata,  // average_value, sample_index, cross_count
    output logic [1:0]                         m_tuser   // average_valid, cross_up
);
    logic [mac_pkg::WIN_BITS-1:0] win_reg;
    logic [mac_pkg::WIN_BITS-1:0] win_eff;
    mac_pkg::mac_cmd_t            cmd;
    mac_pkg::mac_sts_t            sts;
    logic [31:0]                  avg, idx, cnt;
    logic                         avg_valid, cross_flag;

    // window register, ready only while idle with no sample offered
    assign cfg_ready = s_tready && !s_tvalid;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= mac_pkg::WIN_BITS'(1);
        end else if (cfg_valid && cfg_ready) begin
            win_reg <= cfg_data;
        end
    end

    // zero acts as one, oversize clamps to the store depth
    always_comb begin
        priority if (win_reg == '0) begin
            win_eff = mac_pkg::WIN_BITS'(1);
        end else if (32'(win_reg) > 32'(MAX_WINDOW)) begin
            win_eff = mac_pkg::WIN_BITS'(MAX_WINDOW);
        end else begin
            win_eff = win_reg;
        end
    end

    mac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mac_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .win           (win_eff),
        .sample_in     (s_tdata),
        .restart_in    (s_tuser[0]),
        .average_value (avg),
        .average_valid (avg_valid),
        .cross_up      (cross_flag),
        .sample_index  (idx),
        .cross_count   (cnt)
    );

    // result fields held in registers until the transfer completes
    assign m_tdata = {cnt, idx, avg};
    assign m_tuser = {cross_flag, avg_valid};
endmodule
`default_nettype wire

// ===== hdl/mac_checker.sv =====
// port-level checks for the moving average cross detector, bound to the top level
// depends on moving_average_cross_detector
`default_nettype none
module mac_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_cross_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("cross without valid average");

    a_avg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("average nonzero while not valid");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("item accepted without processing");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind moving_average_cross_detector mac_checker u_mac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
